>>> design/cpeg_pkg.sv
// Shared types, widths and sequencer constants of the cabinet post-EQ gain/mix block.
package cpeg_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 30;
  localparam int GUARD_BITS     = 8;
  localparam int GAIN_FRAC_BITS = 28;
  localparam int MIX_FRAC_BITS  = 16;

  localparam int DATA_W     = 32;                          // filter history and outputs
  localparam int B0_W       = 31;
  localparam int GAIN_W     = 32;
  localparam int MIX_W      = MIX_FRAC_BITS + 1;
  localparam int OP_W       = DATA_W + 1;                  // signed operand of the multiplier
  localparam int PROD_W     = 2 * OP_W;
  localparam int ACC_W      = 56;
  localparam int WET_W      = DATA_W + GAIN_W - GAIN_FRAC_BITS;
  localparam int MIX_SPLIT  = WET_W / 2;
  localparam int COEF_SHIFT = COEF_FRAC_BITS - GUARD_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MIX_W-1:0] MIX_ONE = MIX_W'(1) << MIX_FRAC_BITS;

  localparam longint Y_MAX   = (longint'(1) << (DATA_W - 1)) - 1;
  localparam longint Y_MIN   = -Y_MAX - 1;
  localparam longint OUT_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  // Places in a biquad history row
  localparam logic [1:0] H_X1 = 2'd0;
  localparam logic [1:0] H_X2 = 2'd1;
  localparam logic [1:0] H_Y1 = 2'd2;
  localparam logic [1:0] H_Y2 = 2'd3;

  // Sequencer steps
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] BQ_X    = STEP_W'(0);
  localparam logic [STEP_W-1:0] BQ_H0   = STEP_W'(1);
  localparam logic [STEP_W-1:0] BQ_H1   = STEP_W'(2);
  localparam logic [STEP_W-1:0] BQ_A1   = STEP_W'(3);
  localparam logic [STEP_W-1:0] BQ_A2   = STEP_W'(4);
  localparam logic [STEP_W-1:0] BQ_TAIL = STEP_W'(5);
  localparam logic [STEP_W-1:0] BQ_FIN  = STEP_W'(6);
  localparam logic [STEP_W-1:0] BQ_LEN  = STEP_W'(7);

  localparam logic [STEP_W-1:0] STEP_HP     = BQ_LEN;
  localparam logic [STEP_W-1:0] STEP_GAIN   = STEP_W'(2) * BQ_LEN;
  localparam logic [STEP_W-1:0] STEP_WET    = STEP_GAIN + STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_DRY    = STEP_GAIN + STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_WH     = STEP_GAIN + STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_WL     = STEP_GAIN + STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_WL_ACC = STEP_GAIN + STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_LAST   = STEP_GAIN + STEP_W'(6);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LP_B0   = 3'd0,
    CFG_LP_A1   = 3'd1,
    CFG_LP_A2   = 3'd2,
    CFG_HP_B0   = 3'd3,
    CFG_HP_A1   = 3'd4,
    CFG_HP_A2   = 3'd5,
    CFG_GAIN    = 3'd6,
    CFG_WET_MIX = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_WET
  } acc_op_e;

  typedef enum logic [1:0] {
    TERM_RAW,    // product as is
    TERM_COEF,   // coefficient product, floor shift to guard scale
    TERM_COEF2,  // same, doubled
    TERM_HI      // upper wet half, moved up by the split point
  } term_e;

  typedef struct packed {
    acc_op_e acc_op;
    term_e   term;
  } mac_ctrl_t;

endpackage

>>> design/cpeg_in_if.sv
// Input channel: wet and dry sample pair with valid/ready.
interface cpeg_in_if import cpeg_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] wet_sample;
  logic signed [SAMPLE_BITS-1:0] dry_sample;

  modport source (output valid, output wet_sample, output dry_sample, input ready);
  modport sink   (input valid, input wet_sample, input dry_sample, output ready);
endinterface

>>> design/cpeg_out_if.sv
// Output channel: mixed sample with valid/ready.
interface cpeg_out_if import cpeg_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

>>> design/cpeg_mac.sv
// Shared multiplier with registered product, accumulator and rounding/saturation.
module cpeg_mac import cpeg_pkg::*; (
  input  logic                          clk_i,
  input  logic signed [OP_W-1:0]        op_a_i,
  input  logic signed [OP_W-1:0]        op_b_i,
  input  mac_ctrl_t                     ctrl_i,
  output logic signed [DATA_W-1:0]      biq_y_o,
  output logic signed [SAMPLE_BITS-1:0] mix_y_o,
  output logic signed [WET_W-1:0]       wet_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] coef_t;
  logic signed [PROD_W-1:0] wet_r;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [WET_W-1:0]  wet_q, wet_d;
  logic signed [ACC_W-1:0]  biq_r, mix_r;

  assign prod_d = PROD_W'(op_a_i) * PROD_W'(op_b_i);
  assign coef_t = prod_q >>> COEF_SHIFT;

  always_comb begin
    case (ctrl_i.term)
      TERM_COEF:  term = ACC_W'(coef_t);
      TERM_COEF2: term = ACC_W'(coef_t) <<< 1;
      TERM_HI:    term = ACC_W'(prod_q) <<< MIX_SPLIT;
      default:    term = ACC_W'(prod_q);
    endcase
  end

  // round half up by the gain fraction
  assign wet_r = (prod_q + (PROD_W'(1) <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;

  always_comb begin
    acc_d = acc_q;
    wet_d = wet_q;
    case (ctrl_i.acc_op)
      ACC_LOAD: acc_d = term;
      ACC_ADD:  acc_d = acc_q + term;
      ACC_SUB:  acc_d = acc_q - term;
      ACC_WET:  wet_d = WET_W'(wet_r);
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    wet_q  <= wet_d;
  end

  assign biq_r = (acc_q + (ACC_W'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
  assign mix_r = (acc_q + (ACC_W'(1) <<< (MIX_FRAC_BITS - 1))) >>> MIX_FRAC_BITS;

  always_comb begin
    if (biq_r > ACC_W'(Y_MAX)) begin
      biq_y_o = DATA_W'(Y_MAX);
    end else if (biq_r < ACC_W'(Y_MIN)) begin
      biq_y_o = DATA_W'(Y_MIN);
    end else begin
      biq_y_o = DATA_W'(biq_r);
    end
    if (mix_r > ACC_W'(OUT_MAX)) begin
      mix_y_o = SAMPLE_BITS'(OUT_MAX);
    end else if (mix_r < ACC_W'(OUT_MIN)) begin
      mix_y_o = SAMPLE_BITS'(OUT_MIN);
    end else begin
      mix_y_o = SAMPLE_BITS'(mix_r);
    end
  end

  assign wet_o = wet_q;

endmodule

>>> design/cabinet_post_eq_gain_mix.sv
// Top level: post-cabinet lowpass/highpass EQ, makeup gain and dry/wet mix.
//
// Usage:
//   in_i carries one wet (convolved) sample and its dry twin per transfer;
//   out_o returns one mixed, saturated sample per input transfer, in order.
//   The cfg port writes the eight coefficient/gain/mix registers by index;
//   write them only while no sample is in flight.
// Timing:
//   One shared 33x33 multiplier does all fourteen products of an item, one per
//   cycle, under a step counter. The two biquads need seven steps each since
//   the highpass input is the lowpass output; gain takes two, the mix five.
//   in_i.ready is high only while idle, so no new item is taken until the last
//   one has been loaded into the output register.
// Stall:
//   The result sits in an output register; the block goes back to idle at
//   once if that register is free, or holds the final step until out_o.ready
//   frees it.
// Reset:
//   rst_ni clears filter history and restores the default registers
//   (unity b0 and gain, zero feedback, fully wet).
module cabinet_post_eq_gain_mix import cpeg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cpeg_in_if.sink               in_i,
  cpeg_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  logic        [B0_W-1:0]   lp_b0_q, hp_b0_q;
  logic signed [DATA_W-1:0] lp_a1_q, lp_a2_q, hp_a1_q, hp_a2_q;
  logic        [GAIN_W-1:0] gain_q;
  logic        [MIX_W-1:0]  wet_mix_q;

  // item and filter state
  state_e                        state_q, state_d;
  logic [STEP_W-1:0]             step_q;
  logic signed [SAMPLE_BITS-1:0] x_q, dry_q;
  logic signed [DATA_W-1:0]      lp_hist_q [4];
  logic signed [DATA_W-1:0]      hp_hist_q [4];
  logic signed [SAMPLE_BITS-1:0] out_q;
  logic                          out_valid_q;

  // sequencer outputs
  mac_ctrl_t                mac_ctrl;
  logic signed [OP_W-1:0]   op_a, op_b;
  logic                     lp_upd, hp_upd, out_load, step_adv;

  logic signed [DATA_W-1:0]      biq_y;
  logic signed [SAMPLE_BITS-1:0] mix_y;
  logic signed [WET_W-1:0]       wet;

  logic                     in_xfer, out_free, bq_hp;
  logic [STEP_W-1:0]        bq_k;
  logic [MIX_W-1:0]         mix_eff, mix_inv;
  logic        [B0_W-1:0]   bq_b0;
  logic signed [DATA_W-1:0] bq_a1, bq_a2, bq_x;
  logic signed [DATA_W-1:0] bq_h [4];

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Mix settings above one act as one.
  assign mix_eff = (wet_mix_q > MIX_ONE) ? MIX_ONE : wet_mix_q;
  assign mix_inv = MIX_ONE - mix_eff;

  // Pick the biquad that the step counter is in.
  assign bq_hp = (step_q >= STEP_HP);
  assign bq_k  = bq_hp ? (step_q - STEP_HP) : step_q;
  assign bq_b0 = bq_hp ? hp_b0_q : lp_b0_q;
  assign bq_a1 = bq_hp ? hp_a1_q : lp_a1_q;
  assign bq_a2 = bq_hp ? hp_a2_q : lp_a2_q;
  // highpass input is the newest lowpass output
  assign bq_x  = bq_hp ? lp_hist_q[H_Y1] : DATA_W'(x_q);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bq_h[i] = bq_hp ? hp_hist_q[i] : lp_hist_q[i];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_BUSY;
      end
      ST_BUSY: begin
        if (step_q == STEP_LAST && out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Step decode: operands for the multiplier, accumulator op for the product
  // registered at the previous step, and history/output writes.
  always_comb begin
    mac_ctrl = '{acc_op: ACC_HOLD, term: TERM_RAW};
    op_a     = '0;
    op_b     = '0;
    lp_upd   = 1'b0;
    hp_upd   = 1'b0;
    out_load = 1'b0;
    step_adv = 1'b0;
    case (state_q)
      ST_BUSY: begin
        step_adv = 1'b1;
        if (step_q < STEP_GAIN) begin
          case (bq_k)
            BQ_X: begin
              op_a = OP_W'(bq_b0);
              op_b = OP_W'(bq_x);
            end
            BQ_H0: begin
              op_a     = OP_W'(bq_b0);
              op_b     = OP_W'(bq_h[H_X1]);
              mac_ctrl = '{acc_op: ACC_LOAD, term: TERM_COEF};
            end
            BQ_H1: begin
              op_a     = OP_W'(bq_b0);
              op_b     = OP_W'(bq_h[H_X2]);
              // middle tap is +2*b0 for lowpass, -2*b0 for highpass
              mac_ctrl = '{acc_op: (bq_hp ? ACC_SUB : ACC_ADD), term: TERM_COEF2};
            end
            BQ_A1: begin
              op_a     = OP_W'(bq_a1);
              op_b     = OP_W'(bq_h[H_Y1]);
              mac_ctrl = '{acc_op: ACC_ADD, term: TERM_COEF};
            end
            BQ_A2: begin
              op_a     = OP_W'(bq_a2);
              op_b     = OP_W'(bq_h[H_Y2]);
              mac_ctrl = '{acc_op: ACC_SUB, term: TERM_COEF};
            end
            BQ_TAIL: mac_ctrl = '{acc_op: ACC_SUB, term: TERM_COEF};
            BQ_FIN: begin
              lp_upd = !bq_hp;
              hp_upd = bq_hp;
            end
            default: ;
          endcase
        end else begin
          case (step_q)
            STEP_GAIN: begin
              op_a = OP_W'(gain_q);
              op_b = OP_W'(hp_hist_q[H_Y1]);
            end
            STEP_WET: mac_ctrl = '{acc_op: ACC_WET, term: TERM_RAW};
            STEP_DRY: begin
              op_a = OP_W'(mix_inv);
              op_b = OP_W'(dry_q);
            end
            STEP_WH: begin
              op_a     = OP_W'(mix_eff);
              op_b     = OP_W'($signed(wet[WET_W-1:MIX_SPLIT]));
              mac_ctrl = '{acc_op: ACC_LOAD, term: TERM_RAW};
            end
            STEP_WL: begin
              op_a     = OP_W'(mix_eff);
              op_b     = OP_W'(wet[MIX_SPLIT-1:0]);
              mac_ctrl = '{acc_op: ACC_ADD, term: TERM_HI};
            end
            STEP_WL_ACC: mac_ctrl = '{acc_op: ACC_ADD, term: TERM_RAW};
            STEP_LAST: begin
              // hold here until the output register frees up
              out_load = out_free;
              step_adv = 1'b0;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  cpeg_mac u_mac (
    .clk_i   (clk_i),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .ctrl_i  (mac_ctrl),
    .biq_y_o (biq_y),
    .mix_y_o (mix_y),
    .wet_o   (wet)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_b0_q   <= B0_W'(1) << COEF_FRAC_BITS;
      lp_a1_q   <= '0;
      lp_a2_q   <= '0;
      hp_b0_q   <= B0_W'(1) << COEF_FRAC_BITS;
      hp_a1_q   <= '0;
      hp_a2_q   <= '0;
      gain_q    <= GAIN_W'(1) << GAIN_FRAC_BITS;
      wet_mix_q <= MIX_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LP_B0:   lp_b0_q   <= cfg_data_i[B0_W-1:0];
        CFG_LP_A1:   lp_a1_q   <= $signed(cfg_data_i[DATA_W-1:0]);
        CFG_LP_A2:   lp_a2_q   <= $signed(cfg_data_i[DATA_W-1:0]);
        CFG_HP_B0:   hp_b0_q   <= cfg_data_i[B0_W-1:0];
        CFG_HP_A1:   hp_a1_q   <= $signed(cfg_data_i[DATA_W-1:0]);
        CFG_HP_A2:   hp_a2_q   <= $signed(cfg_data_i[DATA_W-1:0]);
        CFG_GAIN:    gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_WET_MIX: wet_mix_q <= cfg_data_i[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, filter history and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        lp_hist_q[i] <= '0;
        hp_hist_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        step_q <= '0;
      end else if (step_adv) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (lp_upd) begin
        lp_hist_q[H_X2] <= lp_hist_q[H_X1];
        lp_hist_q[H_X1] <= bq_x;
        lp_hist_q[H_Y2] <= lp_hist_q[H_Y1];
        lp_hist_q[H_Y1] <= biq_y;
      end
      if (hp_upd) begin
        hp_hist_q[H_X2] <= hp_hist_q[H_X1];
        hp_hist_q[H_X1] <= bq_x;
        hp_hist_q[H_Y2] <= hp_hist_q[H_Y1];
        hp_hist_q[H_Y1] <= biq_y;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q   <= in_i.wet_sample;
      dry_q <= in_i.dry_sample;
    end
    if (out_load) begin
      out_q <= mix_y;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_sample = out_q;

endmodule
